// ===== hdl/okvt_pkg.sv =====
package okvt_pkg;

    localparam int CMD_W      = 3;
    localparam int KEY_IN_W   = 32;
    localparam int VALUE_IN_W = 64;
    localparam int POS_W      = 8;
    localparam int CFG_W      = 9;
    localparam int COUNT_W    = 9;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_UPD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET_KEY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GET_POS = 3'd5;

    localparam logic [1:0] RD_IDX  = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_POS  = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_key;
        logic       wr_val;
        logic       wr_at_count;
        logic       wr_from_mem;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
        logic       out_ok;
    } okvt_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hit;
        logic             scan_end;
        logic             shift_end;
        logic             full;
        logic             pos_valid;
    } okvt_sts_t;

endpackage

// ===== hdl/ordered_key_value_table.sv =====
// Key/value table that keeps its entries packed in insertion order.
// An operation enters on the s_ channel (s_cmd, s_key, s_value, s_position) and
// its result leaves on the m_ channel (m_ok, m_key_out, m_value_out, m_count),
// one result per operation, both with valid/ready transfers.
// The capacity is written through the cfg_ channel, by the user only while the
// block is idle; the block itself does not enforce it. One operation is worked
// at a time. Every key lookup reads the stored entries one at a time through the
// single read port of the entry memories, whose read data is registered, reading
// each in S_SCAN_RD and comparing it in S_SCAN_CMP. A successful erase moves each
// later entry down, reading it in S_SHIFT_RD and writing it in S_SHIFT_WR.
// A get by position or an unused command goes from S_DISPATCH to S_RESP.
// The next operation is accepted as soon as a result is loaded into the output
// register, even while the receiver stalls; that operation then waits in its
// last step until the output register is free.
// Reset empties the table and sets the capacity to 256; stored entries are
// not cleared, since only entries below the count are ever read.
module ordered_key_value_table
    import okvt_pkg::*;
#(
    parameter int ENTRIES    = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [KEY_IN_W-1:0]   s_key,
    input  logic [VALUE_IN_W-1:0] s_value,
    input  logic [POS_W-1:0]      s_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [KEY_IN_W-1:0]   m_key_out,
    output logic [VALUE_IN_W-1:0] m_value_out,
    output logic [COUNT_W-1:0]    m_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    okvt_ctl_t ctl;
    okvt_sts_t sts;

    assign cfg_ready = 1'b1;

    okvt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    okvt_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .s_cmd       (s_cmd),
        .s_key       (s_key),
        .s_value     (s_value),
        .s_position  (s_position),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .m_ok        (m_ok),
        .m_key_out   (m_key_out),
        .m_value_out (m_value_out),
        .m_count     (m_count)
    );

    // A failed operation never returns data.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_key_out == '0 && m_value_out == '0))
        else $error("failed result carries data");

    // The output register is only reloaded when its previous transfer is done.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

    // Only one operation is in flight.
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second operation accepted while busy");

    // The reported count never exceeds the table depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (ENTRIES > 511 || 32'(m_count) <= 32'(ENTRIES)))
        else $error("count beyond table depth");

endmodule

// ===== hdl/okvt_dp.sv =====
module okvt_dp
    import okvt_pkg::*;
#(
    parameter int ENTRIES    = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  okvt_ctl_t             ctl,
    output okvt_sts_t             sts,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [KEY_IN_W-1:0]   s_key,
    input  logic [VALUE_IN_W-1:0] s_value,
    input  logic [POS_W-1:0]      s_position,
    input  logic                  cfg_valid,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic                  m_ok,
    output logic [KEY_IN_W-1:0]   m_key_out,
    output logic [VALUE_IN_W-1:0] m_value_out,
    output logic [COUNT_W-1:0]    m_count
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic [KEY_BITS-1:0]   key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];

    logic [CMD_W-1:0]      op_cmd_reg;
    logic [KEY_BITS-1:0]   op_key_reg;
    logic [VALUE_BITS-1:0] op_val_reg;
    logic [POS_W-1:0]      op_pos_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CFG_W-1:0]      max_entries_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;

    logic                  m_ok_reg;
    logic [KEY_IN_W-1:0]   m_key_out_reg;
    logic [VALUE_IN_W-1:0] m_value_out_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic [CMP_W-1:0]      idx_w;
    logic [CMP_W-1:0]      nxt_w;
    logic [CMP_W-1:0]      cnt_w;
    logic [CMP_W-1:0]      pos_w;
    logic [CMP_W-1:0]      max_w;
    logic [CMP_W-1:0]      cap_w;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_BITS-1:0]   wr_key_data;
    logic [VALUE_BITS-1:0] wr_val_data;

    assign idx_w = CMP_W'(idx_reg);
    assign nxt_w = idx_w + CMP_W'(1);
    assign cnt_w = CMP_W'(count_reg);
    assign pos_w = CMP_W'(op_pos_reg);
    assign max_w = CMP_W'(max_entries_reg);
    assign cap_w = (max_w < CMP_W'(ENTRIES)) ? max_w : CMP_W'(ENTRIES);

    assign sts.cmd       = op_cmd_reg;
    assign sts.hit       = (rd_key_reg == op_key_reg);
    assign sts.scan_end  = (idx_w >= cnt_w);
    assign sts.shift_end = (nxt_w >= cnt_w);
    assign sts.full      = (cnt_w >= cap_w);
    assign sts.pos_valid = (pos_w < cnt_w);

    always_comb begin
        unique case (ctl.rd_sel)
            RD_IDX:  rd_addr = idx_w[IDX_W-1:0];
            RD_NEXT: rd_addr = nxt_w[IDX_W-1:0];
            RD_POS:  rd_addr = pos_w[IDX_W-1:0];
            default: rd_addr = idx_w[IDX_W-1:0];
        endcase
    end

    assign wr_addr     = ctl.wr_at_count ? cnt_w[IDX_W-1:0] : idx_w[IDX_W-1:0];
    assign wr_key_data = ctl.wr_from_mem ? rd_key_reg : op_key_reg;
    assign wr_val_data = ctl.wr_from_mem ? rd_val_reg : op_val_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_key) begin
            key_mem[wr_addr] <= wr_key_data;
        end
        if (ctl.wr_val) begin
            val_mem[wr_addr] <= wr_val_data;
        end
        if (ctl.rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_item) begin
            op_cmd_reg <= s_cmd;
            op_key_reg <= KEY_BITS'(s_key);
            op_val_reg <= VALUE_BITS'(s_value);
            op_pos_reg <= s_position;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (ctl.idx_clr) begin
            idx_next = '0;
        end else if (ctl.idx_inc) begin
            idx_next = idx_reg + CNT_W'(1);
        end
        count_next = count_reg;
        if (ctl.cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.cnt_dec) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg         <= '0;
            count_reg       <= '0;
            max_entries_reg <= CFG_W'(256);
        end else begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cfg_valid) begin
                max_entries_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_ok_reg        <= ctl.out_ok;
            m_key_out_reg   <= (ctl.out_ok && op_cmd_reg == CMD_GET_POS) ?
                               KEY_IN_W'(rd_key_reg) : '0;
            m_value_out_reg <= (ctl.out_ok && (op_cmd_reg == CMD_GET_POS ||
                               op_cmd_reg == CMD_GET_KEY)) ? VALUE_IN_W'(rd_val_reg) : '0;
            m_count_reg     <= COUNT_W'(count_reg);
        end
    end

    assign m_ok        = m_ok_reg;
    assign m_key_out   = m_key_out_reg;
    assign m_value_out = m_value_out_reg;
    assign m_count     = m_count_reg;

endmodule

// ===== hdl/okvt_ctrl.sv =====
module okvt_ctrl
    import okvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  okvt_sts_t sts,
    output okvt_ctl_t ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       ok_reg;
    logic       ok_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        ctl          = '0;
        state_next   = state_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.load_item = 1'b1;
                    ctl.idx_clr   = 1'b1;
                    ok_next       = 1'b0;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.cmd) inside
                    CMD_INSERT, CMD_UPDATE, CMD_INS_UPD, CMD_ERASE, CMD_GET_KEY: begin
                        state_next = S_SCAN_RD;
                    end
                    CMD_GET_POS: begin
                        if (sts.pos_valid) begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = RD_POS;
                            ok_next    = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (sts.scan_end) begin
                    if ((sts.cmd == CMD_INSERT || sts.cmd == CMD_INS_UPD) && !sts.full) begin
                        ctl.wr_key      = 1'b1;
                        ctl.wr_val      = 1'b1;
                        ctl.wr_at_count = 1'b1;
                        ctl.cnt_inc     = 1'b1;
                        ok_next         = 1'b1;
                    end
                    state_next = S_RESP;
                end else begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_IDX;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (sts.hit) begin
                    unique case (sts.cmd) inside
                        CMD_UPDATE, CMD_INS_UPD: begin
                            ctl.wr_val = 1'b1;
                            ok_next    = 1'b1;
                            state_next = S_RESP;
                        end
                        CMD_ERASE: begin
                            state_next = S_SHIFT_RD;
                        end
                        CMD_GET_KEY: begin
                            ok_next    = 1'b1;
                            state_next = S_RESP;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end else begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (sts.shift_end) begin
                    ctl.cnt_dec = 1'b1;
                    ok_next     = 1'b1;
                    state_next  = S_RESP;
                end else begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_NEXT;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ctl.wr_key      = 1'b1;
                ctl.wr_val      = 1'b1;
                ctl.wr_from_mem = 1'b1;
                ctl.idx_inc     = 1'b1;
                state_next      = S_SHIFT_RD;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.out_load = 1'b1;
                    ctl.out_ok   = ok_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule
